FILE: hw/rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// Infix-to-postfix converter package
// Token kinds, error codes, sequencer states, stack control and precedence.
// ----------------------------------------------------------------------------
package itp_pkg;

  typedef enum logic [2:0] {
    KIND_OPEN  = 3'd0,
    KIND_CLOSE = 3'd1,
    KIND_SUB   = 3'd2,
    KIND_ADD   = 3'd3,
    KIND_DIV   = 3'd4,
    KIND_MUL   = 3'd5,
    KIND_NUM   = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NUM,
    ST_CLOSE,
    ST_CLOSE_END,
    ST_OPR,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic  push;
    logic  pop;
    kind_e wdata;
  } stack_ctrl_t;

  localparam int unsigned ValueW = 64;
  localparam int unsigned KindW  = 3;
  localparam int unsigned ErrW   = 2;

  // parentheses bind loosest, then sub/add, then div/mul
  function automatic logic [1:0] prec_of(kind_e kind);
    logic [1:0] prec;
    unique case (kind)
      KIND_OPEN, KIND_CLOSE: prec = 2'd0;
      KIND_SUB, KIND_ADD:    prec = 2'd1;
      default:               prec = 2'd2;
    endcase
    return prec;
  endfunction

endpackage

FILE: hw/rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// Infix-to-postfix converter
// Shunting-yard sequencer around a single operator stack.
// ----------------------------------------------------------------------------
// One token is taken at a time; s_axis_tready_o stays low until the sequencer
// has finished with it. A number is accepted, then emitted. An operator pops
// and emits each stacked operator of equal or higher precedence, then is
// pushed; an open parenthesis is pushed at once. A close parenthesis pops and
// emits operators up to the open, then emits the open and the close (only a
// flagged close if unmatched). A token marked last then pops every entry still
// left on the stack. The single stack port and the single output register
// allow one pop or push and one emitted token per cycle, while the output side
// does not stall. No clearing pass runs after reset.
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [63:0] token_value
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] token_kind
  input  logic        s_axis_tlast_i,   // last_token
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] out_value
  output logic [4:0]  m_axis_tuser_o,   // [2:0] out_kind, [4:3] out_error
  output logic        m_axis_tlast_o    // out_last
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  state_e            state_q, state_d;
  kind_e             kind_q;
  logic [ValueW-1:0] value_q;
  logic              last_q;

  stack_ctrl_t       stk_ctrl;
  logic [CntW-1:0]   stk_count;
  kind_e             stk_top;

  logic              in_fire;
  logic              out_free;
  logic              stk_empty;
  logic              stk_full;
  logic              top_open;
  logic              opr_pop;

  logic              emit;
  kind_e             emit_kind;
  logic [ValueW-1:0] emit_value;
  logic              emit_last;
  err_e              emit_err;

  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [ValueW-1:0] out_value_q;
  logic              out_last_q;
  err_e              out_err_q;

  itp_stack #(
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .count_o (stk_count),
    .top_o   (stk_top)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign stk_empty = (stk_count == '0);
  assign stk_full  = (stk_count == CntW'(STACK_DEPTH));
  assign top_open  = (stk_top == KIND_OPEN);
  // an open parenthesis never pops; an operator pops equal or higher precedence
  assign opr_pop   = (kind_q != KIND_OPEN) && !stk_empty &&
                     (prec_of(stk_top) >= prec_of(kind_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_e'(s_axis_tuser_i);
      value_q <= s_axis_tdata_i;
      last_q  <= s_axis_tlast_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser_i >= KIND_NUM) begin
            state_d = ST_NUM;
          end else if (s_axis_tuser_i == KIND_CLOSE) begin
            state_d = ST_CLOSE;
          end else begin
            state_d = ST_OPR;
          end
        end
      end
      ST_NUM, ST_CLOSE_END: begin
        if (out_free) begin
          state_d = (last_q && !stk_empty) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          if (stk_empty) begin
            state_d = ST_IDLE;
          end else if (top_open) begin
            state_d = ST_CLOSE_END;
          end
        end
      end
      ST_OPR: begin
        if (!opr_pop && (out_free || !stk_full)) begin
          state_d = last_q ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free && stk_count == CntW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs: emitted token and stack control
  always_comb begin
    emit          = 1'b0;
    emit_kind     = stk_top;
    emit_value    = '0;
    emit_last     = 1'b0;
    emit_err      = ERR_NONE;
    stk_ctrl.push = 1'b0;
    stk_ctrl.pop  = 1'b0;
    stk_ctrl.wdata = kind_q;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_NUM: begin
        emit       = out_free;
        emit_kind  = KIND_NUM;
        emit_value = value_q;
        emit_last  = last_q && stk_empty;
      end
      ST_CLOSE: begin
        emit = out_free;
        if (stk_empty) begin
          emit_kind = KIND_CLOSE;
          emit_err  = ERR_UNMATCHED;
          emit_last = last_q;
        end else begin
          stk_ctrl.pop = out_free;
        end
      end
      ST_CLOSE_END: begin
        emit      = out_free;
        emit_kind = KIND_CLOSE;
        emit_last = last_q && stk_empty;
      end
      ST_OPR: begin
        if (opr_pop) begin
          emit         = out_free;
          stk_ctrl.pop = out_free;
        end else if (stk_full) begin
          // drop the token and report it
          emit      = out_free;
          emit_kind = kind_q;
          emit_err  = ERR_OVERFLOW;
        end else begin
          stk_ctrl.push = 1'b1;
        end
      end
      ST_FLUSH: begin
        emit         = out_free;
        stk_ctrl.pop = out_free;
        emit_last    = (stk_count == CntW'(1));
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q  <= emit_kind;
      out_value_q <= emit_value;
      out_last_q  <= emit_last;
      out_err_q   <= emit_err;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_err_q, out_kind_q};
  assign m_axis_tlast_o  = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_last) |=> stk_count == '0)
    else $error("final token emitted with operators left on the stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && emit_err == ERR_OVERFLOW) |-> stk_full)
    else $error("overflow reported on a stack that is not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("new request taken while a token is in progress");

endmodule

FILE: hw/rtl/itp_stack.sv
// ----------------------------------------------------------------------------
// Operator stack
// Single-port stack memory with a registered top-of-stack read and bypass.
// ----------------------------------------------------------------------------
module itp_stack import itp_pkg::*; #(
  parameter int unsigned Depth = 32,
  localparam int unsigned CntW  = $clog2(Depth + 1),
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stack_ctrl_t     ctrl_i,
  output logic [CntW-1:0] count_o,
  output kind_e           top_o
);

  kind_e           mem_q [Depth];
  kind_e           top_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] below_d;

  always_comb begin
    count_d = count_q;
    if (ctrl_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  // address of the entry that becomes the top after this cycle
  assign below_d = count_d - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[count_q[AddrW-1:0]] <= ctrl_i.wdata;
    end
  end

  // forward the pushed kind, otherwise read the new top
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      top_q <= ctrl_i.wdata;
    end else begin
      top_q <= mem_q[below_d[AddrW-1:0]];
    end
  end

  assign count_o = count_q;
  assign top_o   = top_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> count_q != '0)
    else $error("pop from empty operator stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push |-> count_q != CntW'(Depth))
    else $error("push onto full operator stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.push && ctrl_i.pop))
    else $error("push and pop in the same cycle");

endmodule

FILE: tb/postfix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Postfix stream checker
// Watches both stream channels of the converter. Every accepted infix request
// is run through a shunting-yard predictor that keeps its own operator stack.
// Each accepted postfix token is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module postfix_checker import itp_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,    // [63:0] token_value
  input  logic [2:0]  s_tuser_i,    // [2:0] token_kind
  input  logic        s_tlast_i,    // last_token
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [63:0] m_tdata_i,    // [63:0] out_value
  input  logic [4:0]  m_tuser_i,    // [2:0] out_kind, [4:3] out_error
  input  logic        m_tlast_i,    // out_last
  output int          mismatch_count_o,
  output int          pending_o
);

  typedef struct {
    kind_e       kind;
    logic [63:0] value;
    logic        last;
    err_e        err;
  } postfix_tok_t;

  postfix_tok_t postfix_q[$];
  kind_e        op_stack[$];

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  // brackets bind loosest, then sub/add, then div/mul
  function automatic int binding_rank(kind_e kind);
    if (kind == KIND_OPEN || kind == KIND_CLOSE) return 0;
    if (kind == KIND_SUB || kind == KIND_ADD) return 1;
    return 2;
  endfunction

  function automatic void queue_token(kind_e kind, logic [63:0] value, err_e err);
    postfix_tok_t tok;
    tok.kind  = kind;
    tok.value = value;
    tok.last  = 1'b0;
    tok.err   = err;
    postfix_q.push_back(tok);
  endfunction

  function automatic void pop_to_output();
    queue_token(op_stack.pop_back(), '0, ERR_NONE);
  endfunction

  // a push onto a full stack drops the operator and emits it flagged
  function automatic void stack_operator(kind_e kind);
    if (op_stack.size() >= STACK_DEPTH) queue_token(kind, '0, ERR_OVERFLOW);
    else op_stack.push_back(kind);
  endfunction

  function automatic void convert_token(logic [2:0] raw, logic [63:0] value, logic last);
    int           base;
    kind_e        kind;
    postfix_tok_t tail;
    base = postfix_q.size();
    if (raw >= KIND_NUM) begin
      queue_token(KIND_NUM, value, ERR_NONE);
    end else begin
      kind = kind_e'(raw);
      if (kind == KIND_OPEN) begin
        stack_operator(kind);
      end else if (kind == KIND_CLOSE) begin
        while (op_stack.size() > 0 && op_stack[$] != KIND_OPEN) pop_to_output();
        if (op_stack.size() > 0) begin
          pop_to_output();
          queue_token(KIND_CLOSE, '0, ERR_NONE);
        end else begin
          queue_token(KIND_CLOSE, '0, ERR_UNMATCHED);
        end
      end else begin
        while (op_stack.size() > 0 && binding_rank(op_stack[$]) >= binding_rank(kind))
          pop_to_output();
        stack_operator(kind);
      end
    end
    if (last) begin
      while (op_stack.size() > 0) pop_to_output();
      if (postfix_q.size() > base) begin
        tail      = postfix_q.pop_back();
        tail.last = 1'b1;
        postfix_q.push_back(tail);
      end
    end
  endfunction

  task automatic report(string what);
    $display("[%0t] postfix check: %s", $time, what);
    mismatch_count_o++;
  endtask

  task automatic check_token();
    postfix_tok_t want;
    if (postfix_q.size() == 0) begin
      report($sformatf("unexpected token kind %0d value %h", m_tuser_i[2:0], m_tdata_i));
    end else begin
      want = postfix_q.pop_front();
      if (m_tuser_i[2:0] !== want.kind)
        report($sformatf("kind %0d, want %0d", m_tuser_i[2:0], want.kind));
      if (m_tdata_i !== want.value)
        report($sformatf("value %h, want %h", m_tdata_i, want.value));
      if (m_tlast_i !== want.last)
        report($sformatf("last %b, want %b", m_tlast_i, want.last));
      if (m_tuser_i[4:3] !== want.err)
        report($sformatf("error %0d, want %0d", m_tuser_i[4:3], want.err));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      postfix_q.delete();
      op_stack.delete();
    end else begin
      if (s_tvalid_i && s_tready_i) convert_token(s_tuser_i, s_tdata_i, s_tlast_i);
      if (m_tvalid_i && m_tready_i) check_token();
    end
    pending_o = postfix_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix-to-postfix converter testbench
// Sends short directed expressions, then random well-formed, deeply nested
// and junk token runs, with bursty requests and a stalling postfix sink.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import itp_pkg::*;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned TOKEN_TARGET = 450;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 40;
  localparam logic [2:0]  KIND_SEVEN   = 3'd7;

  localparam int READY_FULL   = 0;
  localparam int READY_HALF   = 1;
  localparam int READY_SPARSE = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
  } infix_tok_t;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic [2:0]  s_tuser  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [4:0]  m_tuser;
  logic        m_tlast;

  int mismatch_count;
  int pending;
  int cycle_count = 0;
  int tokens_sent = 0;
  int burst_left  = 0;
  int ready_mode  = READY_FULL;
  int mode_left   = 0;

  infix_tok_t expr_q[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  postfix_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tuser_i       (s_tuser),
    .s_tlast_i       (s_tlast),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .m_tuser_i       (m_tuser),
    .m_tlast_i       (m_tlast),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sink alternates between always ready, coin-flip and mostly stalled
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(READY_FULL, READY_SPARSE);
      mode_left  = $urandom_range(8, 80);
    end
    mode_left--;
    case (ready_mode)
      READY_FULL: m_tready <= 1'b1;
      READY_HALF: m_tready <= 1'($urandom_range(0, 1));
      default:    m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [63:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_token(logic [2:0] kind, logic [63:0] value);
    expr_q.push_back('{kind: kind, value: value});
  endfunction

  // hold valid across a burst; drop it only for a gap
  task automatic send_request(infix_tok_t tok, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= tok.kind;
    s_tdata  <= tok.value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    tokens_sent++;
  endtask

  task automatic send_expression();
    foreach (expr_q[i]) send_request(expr_q[i], i == expr_q.size() - 1);
    expr_q.delete();
  endtask

  task automatic build_well_formed();
    int depth;
    int budget;
    bit want_operand;
    bit done;
    depth        = 0;
    budget       = $urandom_range(1, 24);
    want_operand = 1'b1;
    done         = 1'b0;
    while (!done) begin
      if (want_operand) begin
        if (depth < 6 && $urandom_range(0, 4) == 0) begin
          add_token(KIND_OPEN, rand_value());
          depth++;
        end else begin
          add_token(($urandom_range(0, 15) == 0) ? KIND_SEVEN : KIND_NUM, rand_value());
          want_operand = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(0, 2) == 0) begin
        add_token(KIND_CLOSE, rand_value());
        depth--;
      end else if (expr_q.size() >= budget) begin
        repeat (depth) add_token(KIND_CLOSE, rand_value());
        done = 1'b1;
      end else begin
        add_token(3'($urandom_range(KIND_SUB, KIND_MUL)), rand_value());
        want_operand = 1'b1;
      end
    end
  endtask

  // nest around the stack depth so opens and operators may overflow
  task automatic build_deep();
    int levels;
    levels = $urandom_range(28, 36);
    repeat (levels) add_token(KIND_OPEN, rand_value());
    add_token(KIND_NUM, rand_value());
    add_token(3'($urandom_range(KIND_SUB, KIND_MUL)), rand_value());
    add_token(KIND_NUM, rand_value());
    repeat (levels) add_token(KIND_CLOSE, rand_value());
  endtask

  task automatic build_junk();
    repeat ($urandom_range(1, 10)) add_token(3'($urandom_range(0, 7)), rand_value());
  endtask

  initial begin
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of value, add binding looser than mul
    add_token(KIND_NUM, '0);
    add_token(KIND_ADD, '1);
    add_token(KIND_NUM, '1);
    add_token(KIND_MUL, '0);
    add_token(KIND_NUM, 64'haaaa_5555_aaaa_5555);
    send_expression();
    // brackets, sub and div
    add_token(KIND_OPEN, '0);
    add_token(KIND_NUM, 64'h5555_aaaa_5555_aaaa);
    add_token(KIND_SUB, '0);
    add_token(KIND_NUM, 64'h8000_0000_0000_0001);
    add_token(KIND_CLOSE, '0);
    add_token(KIND_DIV, '0);
    add_token(KIND_NUM, 64'h7fff_ffff_ffff_fffe);
    send_expression();
    // close with no open pops everything and flags it
    add_token(KIND_NUM, 64'd1);
    add_token(KIND_ADD, '0);
    add_token(KIND_NUM, 64'd2);
    add_token(KIND_CLOSE, '0);
    add_token(KIND_NUM, 64'd3);
    send_expression();
    // kind seven passes as a number
    add_token(KIND_SEVEN, 64'hdead_beef_0123_4567);
    send_expression();
    // open left over at the end is flushed
    add_token(KIND_OPEN, '0);
    add_token(KIND_NUM, 64'd9);
    send_expression();
    // last on an operator, then last on an unmatched close
    add_token(KIND_ADD, '1);
    send_expression();
    add_token(KIND_CLOSE, '1);
    send_expression();

    while (tokens_sent < TOKEN_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) build_well_formed();
      else if (pick < 8) build_deep();
      else build_junk();
      send_expression();
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/itp_pkg.sv
hw/rtl/itp_stack.sv
hw/rtl/infix_to_postfix_converter.sv
tb/postfix_checker.sv
tb/tb_top.sv
